>>> hdl/cvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cvp_pkg;

  // frame and kernel limits
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int KERNEL      = 3;
  localparam int WIN         = KERNEL * KERNEL;
  localparam int COL_BITS    = 10;
  localparam int DIM_BITS    = 11;

  // arithmetic widths
  localparam int PIXEL_BITS  = 8;
  localparam int COEF_BITS   = 16;
  localparam int LINE_BITS   = 2 * PIXEL_BITS;
  localparam int PROD_BITS   = PIXEL_BITS + 1 + COEF_BITS;
  localparam int ROW_BITS    = PROD_BITS + 2;
  localparam int VALUE_BITS  = 28;

  // configuration port
  localparam int REG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = KERNEL * COEF_BITS;

  // reset values of the registers
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_KERNEL = 3;

  // queue between front and back
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int LEVEL_BITS  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_WIDTH  = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_PADDED_MODE   = 3'd4,
    REG_COEF_ROW0     = 3'd5,
    REG_COEF_ROW1     = 3'd6,
    REG_COEF_ROW2     = 3'd7
  } reg_index_t;

  typedef struct packed {
    op_t                   operation;
    logic [PIXEL_BITS-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [COL_BITS-1:0]          out_x;
    logic [COL_BITS-1:0]          out_y;
    logic                         last;
  } out_item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]                     image_width;
    logic [DIM_BITS-1:0]                     image_height;
    logic [1:0]                              kernel_width;
    logic [1:0]                              kernel_height;
    logic                                    padded_mode;
    logic [KERNEL-1:0][CFG_DATA_BITS-1:0]    coef_row;
  } cfg_t;

  // output position and frame-end flag of one result
  typedef struct packed {
    logic [COL_BITS-1:0] out_x;
    logic [COL_BITS-1:0] out_y;
    logic                last;
  } pos_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                             compute;
    logic [WIN-1:0][PIXEL_BITS-1:0]   window;
    pos_t                             pos;
  } q_item_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(logic [DIM_BITS-1:0] v,
                                                    logic [DIM_BITS-1:0] hi);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // a two-bit kernel size never exceeds three, only zero needs lifting
  function automatic logic [1:0] clamp_ker(logic [1:0] v);
    return (v == 2'd0) ? 2'd1 : v;
  endfunction

  function automatic logic [DIM_BITS-1:0] eff_width(cfg_t c);
    return clamp_dim(c.image_width, DIM_BITS'(MAX_WIDTH));
  endfunction

  function automatic logic [DIM_BITS-1:0] eff_height(cfg_t c);
    return clamp_dim(c.image_height, DIM_BITS'(MAX_HEIGHT));
  endfunction

endpackage

`default_nettype wire

>>> hdl/conv2d_valid_or_padded.sv
// Sliding-window correlation, kernel up to 3x3, on a raster pixel stream, valid or zero-padded output.
// A result passes the accepted-item register, the queue, the multiply and row-sum stages and the output register.
// Throughput: one item per cycle while pixel_stall is low; each pixel makes one read and one write of the line store.
// Reset: registers return to 640x480, 3x3, valid mode, zero coefficients; the line store
// is then cleared in a pass over every address, during which pixel_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module conv2d_valid_or_padded (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [cvp_pkg::REG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [cvp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  wire logic                                  pixel_valid,
  output logic                                       pixel_stall,
  input  wire cvp_pkg::in_item_t                     pixel_item,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output cvp_pkg::out_item_t                         result_item
);
  import cvp_pkg::*;

  cfg_t                  cfg;
  q_item_t               q_wdata, q_head;
  logic                  q_push, q_pop, q_nonempty;
  logic [LEVEL_BITS-1:0] q_level;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= DIM_BITS'(RESET_WIDTH);
      cfg.image_height  <= DIM_BITS'(RESET_HEIGHT);
      cfg.kernel_width  <= 2'(RESET_KERNEL);
      cfg.kernel_height <= 2'(RESET_KERNEL);
      cfg.padded_mode   <= 1'b0;
      cfg.coef_row      <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[DIM_BITS-1:0];
        REG_KERNEL_WIDTH:  cfg.kernel_width  <= cfg_data[1:0];
        REG_KERNEL_HEIGHT: cfg.kernel_height <= cfg_data[1:0];
        REG_PADDED_MODE:   cfg.padded_mode   <= cfg_data[0];
        REG_COEF_ROW0:     cfg.coef_row[0]   <= cfg_data;
        REG_COEF_ROW1:     cfg.coef_row[1]   <= cfg_data;
        REG_COEF_ROW2:     cfg.coef_row[2]   <= cfg_data;
      endcase
    end
  end

  // front: counters, line store, window, classification
  cvp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_item (pixel_item),
    .q_level    (q_level),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // queue between the two halves
  cvp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .head    (q_head),
    .nonempty(q_nonempty),
    .level   (q_level)
  );

  // back: multiply-accumulate pipeline and output register
  cvp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (q_head),
    .nonempty    (q_nonempty),
    .pop         (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item (result_item)
  );

endmodule

`default_nettype wire

>>> hdl/cvp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cvp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cvp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cvp_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cvp_pkg::cfg_t                 cfg,
  input  wire logic                          pixel_valid,
  output logic                               pixel_stall,
  input  wire cvp_pkg::in_item_t             pixel_item,
  input  wire logic [cvp_pkg::LEVEL_BITS-1:0] q_level,
  output logic                               q_push,
  output cvp_pkg::q_item_t                   q_data
);
  import cvp_pkg::*;

  logic [DIM_BITS-1:0] w, h;
  logic [1:0]          kw, kh;
  logic                ka, kb;

  // line store clearing pass
  logic                clr_active;
  logic [COL_BITS-1:0] clr_addr;

  // input raster position
  logic [COL_BITS-1:0] in_col, in_row, in_col_next, in_row_next;
  logic [DIM_BITS-1:0] ic1, ir1;
  logic                frame_end;
  logic                accept;

  // accepted item held in a register while the line store is read
  logic                  s1_valid;
  op_t                   s1_op;
  logic [PIXEL_BITS-1:0] s1_pixel;
  logic [COL_BITS-1:0]   s1_x, s1_y;
  logic                  s1_frame_end;
  logic                  s1_fwd;
  logic [LINE_BITS-1:0]  s1_fwd_data;
  logic                  s1_push;

  // line store access
  logic                  ram_we;
  logic [COL_BITS-1:0]   ram_waddr;
  logic [LINE_BITS-1:0]  ram_wdata, ram_rdata;
  logic [LINE_BITS-1:0]  line_cur, wr_line;
  logic [PIXEL_BITS-1:0] above1, above2;
  logic                  fwd_hit;

  // window and output raster
  logic [WIN-1:0][PIXEL_BITS-1:0] window, window_next;
  logic [COL_BITS-1:0] out_col, out_row, out_col_next, out_row_next;
  logic                draining, draining_next;
  logic                new_frame;
  logic [COL_BITS-1:0] oc_base, or_base;
  logic                drn_base;
  logic [DIM_BITS-1:0] oc1, or1, x1, y1;
  logic [COL_BITS-1:0] adv_col, adv_row;
  logic                pos_last;
  logic [DIM_BITS:0]   ox_w, oy_w, wa;
  logic                interior, lag_ok, valid_hit;
  logic                emit, compute;
  pos_t                pos;

  assign w  = eff_width(cfg);
  assign h  = eff_height(cfg);
  assign kw = clamp_ker(cfg.kernel_width);
  assign kh = clamp_ker(cfg.kernel_height);
  // a three-wide or three-high kernel is what delays the padded output
  assign ka = (kw == 2'd3);
  assign kb = (kh == 2'd3);

  // room for the item in flight and the one being accepted
  assign pixel_stall = clr_active ||
      ((LEVEL_BITS+1)'(q_level) + (LEVEL_BITS+1)'(s1_valid) >= (LEVEL_BITS+1)'(FIFO_DEPTH));
  assign accept = pixel_valid && !pixel_stall;

  // input position advance
  always_comb begin
    ic1         = {1'b0, in_col} + DIM_BITS'(1);
    ir1         = {1'b0, in_row} + DIM_BITS'(1);
    in_col_next = ic1[COL_BITS-1:0];
    in_row_next = in_row;
    frame_end   = 1'b0;
    if (ic1 >= w) begin
      in_col_next = '0;
      if (ir1 >= h) begin
        in_row_next = '0;
        frame_end   = 1'b1;
      end else begin
        in_row_next = ir1[COL_BITS-1:0];
      end
    end
  end

  // line store data, with the previous item's write forwarded
  always_comb begin
    s1_push  = (s1_op == OP_PUSH);
    line_cur = s1_fwd ? s1_fwd_data : ram_rdata;
    above1   = line_cur[PIXEL_BITS-1:0];
    above2   = line_cur[LINE_BITS-1:PIXEL_BITS];
    wr_line  = {above1, s1_pixel};
    fwd_hit  = s1_valid && s1_push && (s1_x == in_col);
  end

  always_comb begin
    ram_we    = clr_active || (s1_valid && s1_push);
    ram_waddr = clr_active ? clr_addr : s1_x;
    ram_wdata = clr_active ? '0 : wr_line;
  end

  cvp_ram #(
    .WIDTH(LINE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_col),
    .rdata(ram_rdata)
  );

  // window shift on a pushed pixel
  always_comb begin
    window_next = window;
    if (s1_push) begin
      for (int r = 0; r < KERNEL; r++) begin
        window_next[r*KERNEL]   = window[r*KERNEL+1];
        window_next[r*KERNEL+1] = window[r*KERNEL+2];
      end
      window_next[KERNEL-1]   = above2;
      window_next[2*KERNEL-1] = above1;
      window_next[3*KERNEL-1] = s1_pixel;
    end
  end

  // output raster position and its advance
  always_comb begin
    new_frame = s1_push && (s1_x == '0) && (s1_y == '0);
    oc_base   = new_frame ? '0 : out_col;
    or_base   = new_frame ? '0 : out_row;
    drn_base  = new_frame ? 1'b0 : draining;
    oc1       = {1'b0, oc_base} + DIM_BITS'(1);
    or1       = {1'b0, or_base} + DIM_BITS'(1);
    pos_last  = (oc1 >= w) && (or1 >= h);
    adv_col   = oc1[COL_BITS-1:0];
    adv_row   = or_base;
    if (oc1 >= w) begin
      adv_col = '0;
      adv_row = (or1 >= h) ? '0 : or1[COL_BITS-1:0];
    end
  end

  // classification: which result, if any, this item gives
  always_comb begin
    x1     = {1'b0, s1_x} + DIM_BITS'(1);
    y1     = {1'b0, s1_y} + DIM_BITS'(1);
    ox_w   = {2'b0, oc_base} - (DIM_BITS+1)'(kw[1]) + (DIM_BITS+1)'(kw);
    oy_w   = {2'b0, or_base} - (DIM_BITS+1)'(kh[1]) + (DIM_BITS+1)'(kh);
    interior = (oc_base >= COL_BITS'(kw[1])) && (ox_w <= {1'b0, w}) &&
               (or_base >= COL_BITS'(kh[1])) && (oy_w <= {1'b0, h});
    wa     = {1'b0, w} + (DIM_BITS+1)'(ka);
    valid_hit = (x1 >= DIM_BITS'(kw)) && (y1 >= DIM_BITS'(kh));

    // raster index has reached the padded lag
    if (kb) begin
      lag_ok = (s1_y >= COL_BITS'(2)) ||
               ((s1_y == COL_BITS'(1)) && (s1_x >= COL_BITS'(ka))) ||
               ((s1_y == '0) && ((DIM_BITS+1)'(s1_x) >= wa));
    end else begin
      lag_ok = !ka || (s1_x != '0) || (s1_y != '0);
    end

    emit          = 1'b0;
    compute       = 1'b0;
    pos           = '0;
    out_col_next  = oc_base;
    out_row_next  = or_base;
    draining_next = drn_base;

    if (s1_push) begin
      if (!cfg.padded_mode) begin
        if (valid_hit) begin
          emit      = 1'b1;
          compute   = 1'b1;
          pos.out_x = COL_BITS'(x1 - DIM_BITS'(kw));
          pos.out_y = COL_BITS'(y1 - DIM_BITS'(kh));
          pos.last  = (x1 >= w) && (y1 >= h);
        end
      end else if (lag_ok) begin
        emit         = 1'b1;
        compute      = interior;
        pos.out_x    = oc_base;
        pos.out_y    = or_base;
        pos.last     = pos_last;
        out_col_next = adv_col;
        out_row_next = adv_row;
      end
      if (cfg.padded_mode && s1_frame_end && (ka || kb)) begin
        draining_next = 1'b1;
      end
    end else if (cfg.padded_mode && draining) begin
      // flush one border pixel of the padded frame
      emit         = 1'b1;
      pos.out_x    = oc_base;
      pos.out_y    = or_base;
      pos.last     = pos_last;
      out_col_next = adv_col;
      out_row_next = adv_row;
      if (pos_last) begin
        draining_next = 1'b0;
      end
    end
  end

  always_comb begin
    q_push         = s1_valid && emit;
    q_data.compute = compute;
    q_data.window  = window_next;
    q_data.pos     = pos;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      in_col     <= '0;
      in_row     <= '0;
      s1_valid   <= 1'b0;
      window     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      draining   <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + COL_BITS'(1);
        if (clr_addr == COL_BITS'(MAX_WIDTH - 1)) begin
          clr_active <= 1'b0;
        end
      end
      s1_valid <= accept;
      if (accept && (pixel_item.operation == OP_PUSH)) begin
        in_col <= in_col_next;
        in_row <= in_row_next;
      end
      if (s1_valid) begin
        window   <= window_next;
        out_col  <= out_col_next;
        out_row  <= out_row_next;
        draining <= draining_next;
      end
    end
  end

  // accepted item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op        <= pixel_item.operation;
      s1_pixel     <= pixel_item.pixel;
      s1_x         <= in_col;
      s1_y         <= in_row;
      s1_frame_end <= frame_end;
      s1_fwd       <= fwd_hit;
      s1_fwd_data  <= wr_line;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cvp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cvp_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire cvp_pkg::q_item_t               wdata,
  input  wire logic                           pop,
  output cvp_pkg::q_item_t                    head,
  output logic                                nonempty,
  output logic [cvp_pkg::LEVEL_BITS-1:0]      level
);
  import cvp_pkg::*;

  q_item_t             mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;

  assign head     = mem[rd_ptr];
  assign nonempty = (level != '0);

  // pointers and fill level; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        level <= level + LEVEL_BITS'(1);
      end else if (pop && !push) begin
        level <= level - LEVEL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cvp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cvp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cvp_pkg::cfg_t      cfg,
  input  wire cvp_pkg::q_item_t   head,
  input  wire logic               nonempty,
  output logic                    pop,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output cvp_pkg::out_item_t      result_item
);
  import cvp_pkg::*;

  logic [1:0] kw, kh;
  logic signed [COEF_BITS-1:0] coef_eff [WIN];
  logic signed [PROD_BITS-1:0] prod_c [WIN];

  // multiply stage
  logic                        b1_valid;
  logic signed [PROD_BITS-1:0] b1_prod [WIN];
  pos_t                        b1_pos;

  // row sum stage
  logic                        b2_valid;
  logic signed [ROW_BITS-1:0]  b2_rows [KERNEL];
  logic signed [ROW_BITS-1:0]  row_c [KERNEL];
  pos_t                        b2_pos;
  logic signed [VALUE_BITS-1:0] total;

  logic adv_out, adv2, adv1;

  // coefficient for window cell (r, c), zero outside the kernel in use
  function automatic logic signed [COEF_BITS-1:0] coef_for(cfg_t c, logic [1:0] kwv,
                                                           logic [1:0] khv, int r, int col);
    int j;
    int i;
    logic [KERNEL-1:0][COEF_BITS-1:0] slots;
    logic signed [COEF_BITS-1:0] res;
    j = r + int'(khv) - KERNEL;
    i = col + int'(kwv) - KERNEL;
    res = '0;
    if (j >= 0 && i >= 0) begin
      slots = c.coef_row[2'(j)];
      res   = slots[2'(i)];
    end
    return res;
  endfunction

  assign kw = clamp_ker(cfg.kernel_width);
  assign kh = clamp_ker(cfg.kernel_height);

  always_comb begin
    for (int r = 0; r < KERNEL; r++) begin
      for (int c = 0; c < KERNEL; c++) begin
        coef_eff[r*KERNEL+c] = coef_for(cfg, kw, kh, r, c);
      end
    end
  end

  // nine products in parallel, zero for border and flushed items
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      if (head.compute) begin
        prod_c[k] = $signed({1'b0, head.window[k]}) * coef_eff[k];
      end else begin
        prod_c[k] = '0;
      end
    end
  end

  // row sums, then the total; nine 8x16 products cannot leave 28 bits
  always_comb begin
    for (int r = 0; r < KERNEL; r++) begin
      row_c[r] = ROW_BITS'(b1_prod[r*KERNEL]) + ROW_BITS'(b1_prod[r*KERNEL+1]) +
                 ROW_BITS'(b1_prod[r*KERNEL+2]);
    end
    total = VALUE_BITS'(b2_rows[0]) + VALUE_BITS'(b2_rows[1]) + VALUE_BITS'(b2_rows[2]);
  end

  // stage enables
  assign adv_out = !result_valid || !result_stall;
  assign adv2    = !b2_valid || adv_out;
  assign adv1    = !b1_valid || adv2;
  assign pop     = nonempty && adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid     <= 1'b0;
      b2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv1) begin
        b1_valid <= nonempty;
      end
      if (adv2) begin
        b2_valid <= b1_valid;
      end
      if (adv_out) begin
        result_valid <= b2_valid;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (pop) begin
      b1_prod <= prod_c;
      b1_pos  <= head.pos;
    end
    if (adv2 && b1_valid) begin
      b2_rows <= row_c;
      b2_pos  <= b1_pos;
    end
    if (adv_out && b2_valid) begin
      result_item.value <= total;
      result_item.out_x <= b2_pos.out_x;
      result_item.out_y <= b2_pos.out_y;
      result_item.last  <= b2_pos.last;
    end
  end

endmodule

`default_nettype wire
